// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WFAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WFAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/wfac_pkg.sv -----
package wfac_pkg;

   // Defaults for the top-level parameters.
   localparam int ADDR_WIDTH_DEF    = 20;
   localparam int MAX_SEGMENTS_DEF  = 2048;
   localparam int HISTORY_DEPTH_DEF = 1024;

   // Fixed port widths.
   localparam int SIZE_W = 21;
   localparam int LEN_W  = 21;
   localparam int TGT_W  = 10;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 21'h100000;

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_DEC,
      ST_A_SHR,
      ST_A_SHW,
      ST_A_SPLIT,
      ST_A_TAKE,
      ST_F_MOD,
      ST_F_H,
      ST_F_RD,
      ST_F_CHK,
      ST_F_RRD,
      ST_F_RCHK,
      ST_F_MERGE,
      ST_F_SHR,
      ST_F_SHW,
      ST_F_DONE
   } state_type;

endpackage

// ----- hdl/wfac_ram.sv -----
module wfac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- hdl/worst_fit_allocator_coalescing.sv -----
// An allocate scans every segment in the table, then refuses, takes an exact fit, or shifts the
// entries above the chosen segment up and splits it; a free first reduces its target modulo
// HISTORY_DEPTH, then looks the segment up and merges it with free neighbours, moving entries
// down over the folded slots. Throughput: one transaction at a time.
// Reset (synchronous) and every memory_size write start a clearing pass over all HISTORY_DEPTH
// history entries, with busy high. Results are one-cycle strobes that cannot be stalled.
module worst_fit_allocator_coalescing #(
   parameter int ADDR_WIDTH    = wfac_pkg::ADDR_WIDTH_DEF,
   parameter int MAX_SEGMENTS  = wfac_pkg::MAX_SEGMENTS_DEF,
   parameter int HISTORY_DEPTH = wfac_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic [wfac_pkg::LEN_W-1:0]  req_alloc_length,
   input  logic [wfac_pkg::TGT_W-1:0]  req_target_request,
   output logic                        rsp_valid,
   output logic                        rsp_granted,
   output logic [ADDR_WIDTH-1:0]       rsp_start_address,
   input  logic                        csr_write_enable,
   input  logic [wfac_pkg::SIZE_W-1:0] csr_memory_size
);

   import wfac_pkg::*;

   localparam int SEG_IW  = $clog2(MAX_SEGMENTS);
   localparam int CNT_W   = SEG_IW + 1;
   localparam int HIST_IW = $clog2(HISTORY_DEPTH);
   localparam int HCNT_W  = HIST_IW + 1;
   localparam int SL_W    = ADDR_WIDTH + 1;
   localparam int CMP_W   = (SL_W > LEN_W) ? SL_W : LEN_W;
   localparam int TC_W    = (TGT_W > HCNT_W) ? TGT_W : HCNT_W;
   localparam int SEG_W   = ADDR_WIDTH + SL_W + 1;
   localparam int HIST_W  = ADDR_WIDTH + 1;

   localparam logic [CMP_W-1:0]   CAP       = CMP_W'(1) << ADDR_WIDTH;
   localparam logic [TC_W-1:0]    HDEPTH    = TC_W'(HISTORY_DEPTH);
   localparam logic [HIST_IW-1:0] HLAST     = HIST_IW'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0]   SEG_LIMIT = CNT_W'(MAX_SEGMENTS);

   // Clamp a pool size to the address space.
   function automatic logic [SL_W-1:0] cap_size(input logic [SIZE_W-1:0] v);
      logic [SL_W-1:0] r;
      if (CMP_W'(v) > CAP) begin
         r = CAP[SL_W-1:0];
      end else begin
         r = SL_W'(v);
      end
      return r;
   endfunction

   localparam logic [SL_W-1:0] SIZE_RST_C = cap_size(SIZE_RESET);

   // Control registers.
   state_type state_ff, state_in;
   logic [SL_W-1:0]    size_ff, size_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [HIST_IW-1:0] ctr_ff, ctr_in;
   logic [HIST_IW-1:0] clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [TGT_W-1:0]      tgt_ff, tgt_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  found_ff, found_in;
   logic [CNT_W-1:0]      best_idx_ff, best_idx_in;
   logic [SL_W-1:0]       best_len_ff, best_len_in;
   logic [ADDR_WIDTH-1:0] best_start_ff, best_start_in;
   logic [ADDR_WIDTH-1:0] hstart_ff, hstart_in;
   logic [CNT_W-1:0]      kidx_ff, kidx_in;
   logic [ADDR_WIDTH-1:0] kstart_ff, kstart_in;
   logic [SL_W-1:0]       klen_ff, klen_in;
   logic [ADDR_WIDTH-1:0] pstart_ff, pstart_in;
   logic [SL_W-1:0]       plen_ff, plen_in;
   logic                  pfree_ff, pfree_in;
   logic [SL_W-1:0]       rlen_ff, rlen_in;
   logic                  rfree_ff, rfree_in;
   logic [1:0]            rm_ff, rm_in;
   logic                  granted_ff, granted_in;
   logic [ADDR_WIDTH-1:0] rsp_start_ff, rsp_start_in;

   // Memory ports.
   logic                  seg_we;
   logic [SEG_IW-1:0]     seg_waddr, seg_raddr;
   logic [SEG_W-1:0]      seg_wdata, seg_rdata;
   logic                  hist_we;
   logic [HIST_IW-1:0]    hist_waddr, hist_raddr;
   logic [HIST_W-1:0]     hist_wdata, hist_rdata;

   // Fields of the entries read back.
   logic [ADDR_WIDTH-1:0] rd_start;
   logic [SL_W-1:0]       rd_len;
   logic                  rd_free;
   logic                  h_live;
   logic [ADDR_WIDTH-1:0] h_start;

   assign rd_start = seg_rdata[SEG_W-1 -: ADDR_WIDTH];
   assign rd_len   = seg_rdata[SL_W:1];
   assign rd_free  = seg_rdata[0];
   assign h_live   = hist_rdata[HIST_W-1];
   assign h_start  = hist_rdata[ADDR_WIDTH-1:0];

   // Shared decision terms.
   logic             scan_more, alloc_ok, alloc_split, tgt_wrap, seg_hit, has_right;
   logic             a_shift_more, f_shift_more;
   logic [CNT_W-1:0] f_src;

   assign scan_more    = idx_ff < cnt_ff;
   assign alloc_ok     = found_ff && (len_ff != '0) &&
                         (CMP_W'(best_len_ff) >= CMP_W'(len_ff)) &&
                         ((CMP_W'(best_len_ff) == CMP_W'(len_ff)) || (cnt_ff < SEG_LIMIT));
   assign alloc_split  = CMP_W'(best_len_ff) != CMP_W'(len_ff);
   assign tgt_wrap     = TC_W'(tgt_ff) >= HDEPTH;
   assign seg_hit      = (rd_start == hstart_ff) && !rd_free;
   assign has_right    = (kidx_ff + CNT_W'(1)) < cnt_ff;
   assign a_shift_more = idx_ff > (best_idx_ff + CNT_W'(1));
   assign f_src        = idx_ff + CNT_W'(rm_ff);
   assign f_shift_more = (rm_ff != 2'd0) && (f_src < cnt_ff);

   wfac_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
      .clock (clock),
      .we    (seg_we),
      .waddr (seg_waddr),
      .wdata (seg_wdata),
      .raddr (seg_raddr),
      .rdata (seg_rdata)
   );

   wfac_ram #(.WIDTH(HIST_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   state_in = (clr_ff == HLAST) ? ST_IDLE : ST_CLEAR;
         ST_IDLE: begin
            if (start) begin
               state_in = (req_operation == OP_ALLOC) ? ST_A_RD : ST_F_MOD;
            end
         end
         ST_A_RD:    state_in = scan_more ? ST_A_CHK : ST_A_DEC;
         ST_A_CHK:   state_in = ST_A_RD;
         ST_A_DEC: begin
            if (!alloc_ok) begin
               state_in = ST_IDLE;
            end else if (alloc_split) begin
               state_in = ST_A_SHR;
            end else begin
               state_in = ST_A_TAKE;
            end
         end
         ST_A_SHR:   state_in = a_shift_more ? ST_A_SHW : ST_A_SPLIT;
         ST_A_SHW:   state_in = ST_A_SHR;
         ST_A_SPLIT: state_in = ST_A_TAKE;
         ST_A_TAKE:  state_in = ST_IDLE;
         ST_F_MOD:   state_in = tgt_wrap ? ST_F_MOD : ST_F_H;
         ST_F_H:     state_in = h_live ? ST_F_RD : ST_F_DONE;
         ST_F_RD:    state_in = scan_more ? ST_F_CHK : ST_F_DONE;
         ST_F_CHK:   state_in = seg_hit ? ST_F_RRD : ST_F_RD;
         ST_F_RRD:   state_in = has_right ? ST_F_RCHK : ST_F_MERGE;
         ST_F_RCHK:  state_in = ST_F_MERGE;
         ST_F_MERGE: state_in = ST_F_SHR;
         ST_F_SHR:   state_in = f_shift_more ? ST_F_SHW : ST_F_DONE;
         ST_F_SHW:   state_in = ST_F_SHR;
         ST_F_DONE:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
      if (csr_write_enable) begin
         state_in = ST_CLEAR;
      end
   end

   // Datapath and memory control for each state.
   always_comb begin
      logic [SL_W-1:0] merged;
      size_in       = size_ff;
      cnt_in        = cnt_ff;
      ctr_in        = ctr_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      len_in        = len_ff;
      tgt_in        = tgt_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      hstart_in     = hstart_ff;
      kidx_in       = kidx_ff;
      kstart_in     = kstart_ff;
      klen_in       = klen_ff;
      pstart_in     = pstart_ff;
      plen_in       = plen_ff;
      pfree_in      = pfree_ff;
      rlen_in       = rlen_ff;
      rfree_in      = rfree_ff;
      rm_in         = rm_ff;
      granted_in    = granted_ff;
      rsp_start_in  = rsp_start_ff;
      seg_we        = 1'b0;
      seg_waddr     = idx_ff[SEG_IW-1:0];
      seg_wdata     = seg_rdata;
      seg_raddr     = idx_ff[SEG_IW-1:0];
      hist_we       = 1'b0;
      hist_waddr    = ctr_ff;
      hist_wdata    = '0;
      hist_raddr    = HIST_IW'(tgt_ff);
      merged        = klen_ff + (rfree_ff ? rlen_ff : '0);

      case (state_ff)
         ST_CLEAR: begin
            // Mark one history entry dead; the first step also lays down the pool.
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            clr_in     = clr_ff + HIST_IW'(1);
            if (clr_ff == '0) begin
               seg_we    = 1'b1;
               seg_waddr = '0;
               seg_wdata = {ADDR_WIDTH'(0), size_ff, 1'b1};
            end
         end
         ST_IDLE: begin
            len_in      = req_alloc_length;
            tgt_in      = req_target_request;
            idx_in      = '0;
            found_in    = 1'b0;
            best_len_in = '0;
            pfree_in    = 1'b0;
         end
         ST_A_RD: begin
            seg_raddr = idx_ff[SEG_IW-1:0];
         end
         ST_A_CHK: begin
            // Keep the first largest free segment.
            if (rd_free && (rd_len > best_len_ff)) begin
               found_in      = 1'b1;
               best_idx_in   = idx_ff;
               best_len_in   = rd_len;
               best_start_in = rd_start;
            end
            idx_in = idx_ff + CNT_W'(1);
         end
         ST_A_DEC: begin
            idx_in = cnt_ff;
            if (!alloc_ok) begin
               hist_we      = 1'b1;
               rsp_valid_in = 1'b1;
               granted_in   = 1'b0;
               rsp_start_in = '0;
               ctr_in       = (ctr_ff == HLAST) ? '0 : ctr_ff + HIST_IW'(1);
            end
         end
         ST_A_SHR: begin
            seg_raddr = SEG_IW'(idx_ff - CNT_W'(1));
         end
         ST_A_SHW: begin
            // Move one entry up to open the slot after the chosen segment.
            seg_we    = 1'b1;
            seg_waddr = idx_ff[SEG_IW-1:0];
            idx_in    = idx_ff - CNT_W'(1);
         end
         ST_A_SPLIT: begin
            seg_we    = 1'b1;
            seg_waddr = SEG_IW'(best_idx_ff + CNT_W'(1));
            seg_wdata = {best_start_ff + ADDR_WIDTH'(len_ff),
                         best_len_ff - SL_W'(len_ff), 1'b1};
            cnt_in    = cnt_ff + CNT_W'(1);
         end
         ST_A_TAKE: begin
            seg_we       = 1'b1;
            seg_waddr    = best_idx_ff[SEG_IW-1:0];
            seg_wdata    = {best_start_ff, SL_W'(len_ff), 1'b0};
            hist_we      = 1'b1;
            hist_wdata   = {1'b1, best_start_ff};
            rsp_valid_in = 1'b1;
            granted_in   = 1'b1;
            rsp_start_in = best_start_ff;
            ctr_in       = (ctr_ff == HLAST) ? '0 : ctr_ff + HIST_IW'(1);
         end
         ST_F_MOD: begin
            // Reduce the target modulo the history depth, one subtraction a cycle.
            if (tgt_wrap) begin
               tgt_in = tgt_ff - TGT_W'(HISTORY_DEPTH);
            end
         end
         ST_F_H: begin
            hstart_in = h_start;
            if (h_live) begin
               hist_we    = 1'b1;
               hist_waddr = HIST_IW'(tgt_ff);
            end
         end
         ST_F_RD: begin
            seg_raddr = idx_ff[SEG_IW-1:0];
         end
         ST_F_CHK: begin
            if (seg_hit) begin
               kidx_in   = idx_ff;
               kstart_in = rd_start;
               klen_in   = rd_len;
            end else begin
               pstart_in = rd_start;
               plen_in   = rd_len;
               pfree_in  = rd_free;
               idx_in    = idx_ff + CNT_W'(1);
            end
            rfree_in = 1'b0;
         end
         ST_F_RRD: begin
            seg_raddr = SEG_IW'(kidx_ff + CNT_W'(1));
         end
         ST_F_RCHK: begin
            rfree_in = rd_free;
            rlen_in  = rd_len;
         end
         ST_F_MERGE: begin
            // Write the merged free segment and note how many entries fold away.
            seg_we = 1'b1;
            if (pfree_ff) begin
               seg_waddr = SEG_IW'(kidx_ff - CNT_W'(1));
               seg_wdata = {pstart_ff, plen_ff + merged, 1'b1};
               idx_in    = kidx_ff;
               rm_in     = rfree_ff ? 2'd2 : 2'd1;
            end else begin
               seg_waddr = kidx_ff[SEG_IW-1:0];
               seg_wdata = {kstart_ff, merged, 1'b1};
               idx_in    = kidx_ff + CNT_W'(1);
               rm_in     = rfree_ff ? 2'd1 : 2'd0;
            end
         end
         ST_F_SHR: begin
            seg_raddr = f_src[SEG_IW-1:0];
            if (!f_shift_more) begin
               cnt_in = cnt_ff - CNT_W'(rm_ff);
            end
         end
         ST_F_SHW: begin
            // Move one entry down over the folded slots.
            seg_we    = 1'b1;
            seg_waddr = idx_ff[SEG_IW-1:0];
            idx_in    = idx_ff + CNT_W'(1);
         end
         ST_F_DONE: begin
            hist_we = 1'b1;
            ctr_in  = (ctr_ff == HLAST) ? '0 : ctr_ff + HIST_IW'(1);
         end
         default: begin
         end
      endcase

      // A pool size write rebuilds the pool and restarts the history.
      if (csr_write_enable) begin
         size_in = cap_size(csr_memory_size);
         cnt_in  = (cap_size(csr_memory_size) != '0) ? CNT_W'(1) : '0;
         ctr_in  = '0;
         clr_in  = '0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         size_ff      <= SIZE_RST_C;
         cnt_ff       <= CNT_W'(1);
         ctr_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         cnt_ff       <= cnt_in;
         ctr_ff       <= ctr_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      tgt_ff        <= tgt_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      hstart_ff     <= hstart_in;
      kidx_ff       <= kidx_in;
      kstart_ff     <= kstart_in;
      klen_ff       <= klen_in;
      pstart_ff     <= pstart_in;
      plen_ff       <= plen_in;
      pfree_ff      <= pfree_in;
      rlen_ff       <= rlen_in;
      rfree_ff      <= rfree_in;
      rm_ff         <= rm_in;
      granted_ff    <= granted_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = granted_ff;
   assign rsp_start_address = rsp_start_ff;

endmodule

// ----- hdl/wfac_checker.sv -----
`include "assert_macros.svh"

module wfac_checker #(
   parameter int ADDR_WIDTH = wfac_pkg::ADDR_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic                  rsp_granted,
   input logic [ADDR_WIDTH-1:0] rsp_start_address
);

   // A refused allocation reports address zero.
   `WFAC_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_granted, rsp_start_address == '0, "nonzero start on failed allocation")

   // A result comes out as the block goes idle.
   `WFAC_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result while busy")

   // An accepted transaction occupies the block.
   `WFAC_ASSERT_NEXT(a_take_busy, start && !busy, busy, "block not busy after accept")

   // Results never come back to back.
   `WFAC_ASSERT_NEXT(a_rsp_gap, rsp_valid, !rsp_valid, "results in adjacent cycles")

   // Leaving reset starts the history clearing pass.
   `WFAC_ASSERT_NOW(a_reset_clear, $fell(reset), busy, "not busy after reset")

endmodule

bind worst_fit_allocator_coalescing wfac_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_wfac_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_granted       (rsp_granted),
   .rsp_start_address (rsp_start_address)
);
